// File: hdl/kwm_pkg.sv
package kwm_pkg;

	// heap size default
	localparam int SOURCES_DEF = 16;

	localparam int KEY_W   = 64;
	localparam int SRC_W   = 4;
	localparam int SIZE_W  = 32;
	localparam int COUNT_W = 5;

	// command modes
	localparam logic [1:0] MODE_INSERT  = 2'd0;
	localparam logic [1:0] MODE_REFILL  = 2'd1;
	localparam logic [1:0] MODE_EXHAUST = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic [SRC_W-1:0]  source;
		logic [KEY_W-1:0]  new_key;
		logic [SIZE_W-1:0] new_size;
	} cmd_t;

	typedef struct packed {
		logic               popped_valid;
		logic [SRC_W-1:0]   popped_source;
		logic [KEY_W-1:0]   popped_key;
		logic [SIZE_W-1:0]  popped_size;
		logic               refused;
		logic               top_valid;
		logic [SRC_W-1:0]   top_source;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	// one heap entry as stored in memory
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [SRC_W-1:0]  source;
		logic [SIZE_W-1:0] size;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// status from the sequencer to the top level
	typedef struct packed {
		logic done;
		logic popped_valid;
		logic refused;
	} stat_t;

endpackage

// File: hdl/kwm_ram.sv
module kwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hdl/kwm_ctrl.sv
module kwm_ctrl #(
	parameter int SOURCES = 16,
	parameter int AW      = $clog2(SOURCES),
	parameter int CW      = $clog2(SOURCES + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  kwm_pkg::cmd_t   cmd,
	input  kwm_pkg::entry_t root,
	output kwm_pkg::stat_t  stat,
	output kwm_pkg::entry_t popped,
	output logic [CW-1:0]   count,
	output logic            wr_en,
	output logic [AW-1:0]   wr_addr,
	output kwm_pkg::entry_t wr_data,
	output logic            rd_en,
	output logic [AW-1:0]   rd_addr,
	input  kwm_pkg::entry_t rd_data
);

	import kwm_pkg::*;

	localparam int XW = AW + 2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LAST_CAP,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RL,
		S_DN_RR,
		S_DN_CMP
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic [AW-1:0]  pos_q;
	entry_t         cur_q;
	entry_t         best_q;
	logic           best_child_q;
	logic [AW-1:0]  best_idx_q;
	logic           rvalid_q;
	entry_t         popped_q;
	logic           popped_valid_q;
	logic           refused_q;
	logic           done_q;

	logic [CW-1:0]  cnt_m1;
	logic [AW-1:0]  parent;
	logic [XW-1:0]  lc;
	logic [XW-1:0]  rc;
	logic [XW-1:0]  count_x;
	logic           lc_ok;
	logic           rc_ok;
	logic [KEY_W-1:0] cmp_a;
	logic [KEY_W-1:0] cmp_b;
	logic           lt;
	logic           right_wins;

	// heap index arithmetic
	assign cnt_m1  = count_q - CW'(1);
	assign parent  = (pos_q - AW'(1)) >> 1;
	assign lc      = XW'({pos_q, 1'b1});
	assign rc      = lc + XW'(1);
	assign count_x = XW'(count_q);
	assign lc_ok   = lc < count_x;
	assign rc_ok   = rc < count_x;

	// shared key comparator, operands picked by the sequencer step
	always_comb begin
		unique case (state_q)
			S_UP_CMP: begin
				cmp_a = cur_q.key;
				cmp_b = rd_data.key;
			end
			S_DN_RR: begin
				cmp_a = rd_data.key;
				cmp_b = cur_q.key;
			end
			default: begin
				cmp_a = rd_data.key;
				cmp_b = best_q.key;
			end
		endcase
	end

	assign lt         = cmp_a < cmp_b;
	assign right_wins = rvalid_q && lt;

	// memory requests
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cnt_m1[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = cur_q;
		unique case (state_q)
			S_IDLE: begin
				rd_en = start && (cmd.mode == MODE_EXHAUST) && (count_q > CW'(1));
			end
			S_UP_RD: begin
				rd_en   = (pos_q != '0);
				rd_addr = parent;
				wr_en   = (pos_q == '0);
			end
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (lt) begin
					wr_data = rd_data;
				end
			end
			S_DN_RL: begin
				rd_en   = lc_ok;
				rd_addr = lc[AW-1:0];
				wr_en   = !lc_ok;
			end
			S_DN_RR: begin
				rd_en   = rc_ok;
				rd_addr = rc[AW-1:0];
			end
			S_DN_CMP: begin
				wr_en = 1'b1;
				if (right_wins) begin
					wr_data = rd_data;
				end else begin
					wr_data = best_q;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						popped_q       <= '0;
						popped_valid_q <= 1'b0;
						refused_q      <= 1'b0;
						if (cmd.mode == MODE_INSERT) begin
							if (count_q >= CW'(SOURCES)) begin
								refused_q <= 1'b1;
								done_q    <= 1'b1;
							end else begin
								cur_q   <= '{key: cmd.new_key, source: cmd.source,
									size: cmd.new_size};
								pos_q   <= count_q[AW-1:0];
								count_q <= count_q + CW'(1);
								state_q <= S_UP_RD;
							end
						end else if (cmd.mode == MODE_REFILL || cmd.mode == MODE_EXHAUST) begin
							if (count_q == '0) begin
								refused_q <= 1'b1;
								done_q    <= 1'b1;
							end else begin
								popped_q       <= root;
								popped_valid_q <= 1'b1;
								pos_q          <= '0;
								if (cmd.mode == MODE_REFILL) begin
									cur_q   <= '{key: cmd.new_key, source: root.source,
										size: cmd.new_size};
									state_q <= S_DN_RL;
								end else begin
									count_q <= cnt_m1;
									if (cnt_m1 == '0) begin
										done_q <= 1'b1;
									end else begin
										state_q <= S_LAST_CAP;
									end
								end
							end
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_LAST_CAP: begin
					cur_q   <= rd_data;
					state_q <= S_DN_RL;
				end
				S_UP_RD: begin
					if (pos_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (lt) begin
						pos_q   <= parent;
						state_q <= S_UP_RD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DN_RL: begin
					if (lc_ok) begin
						state_q <= S_DN_RR;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DN_RR: begin
					rvalid_q <= rc_ok;
					if (lt) begin
						best_q       <= rd_data;
						best_child_q <= 1'b1;
						best_idx_q   <= lc[AW-1:0];
					end else begin
						best_q       <= cur_q;
						best_child_q <= 1'b0;
						best_idx_q   <= pos_q;
					end
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (right_wins) begin
						pos_q   <= rc[AW-1:0];
						state_q <= S_DN_RL;
					end else if (best_child_q) begin
						pos_q   <= best_idx_q;
						state_q <= S_DN_RL;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign count  = count_q;
	assign popped = popped_q;
	assign stat   = '{done: done_q, popped_valid: popped_valid_q, refused: refused_q};

endmodule

// File: hdl/kway_merge_min_heap_unit.sv
// k-way merge min-heap unit
//
// A binary min-heap of (key, source, size) records that orders the heads of
// sorted sources. A command is transferred at a rising edge with start high
// and busy low: insert places a primed record and sifts it up (refused when
// the heap is full), refill pops the root and replaces it with the same
// source's next record, exhausted pops the root and moves the last entry up.
// Pops on an empty heap are refused; mode 3 does nothing.
//
// Each command gives exactly one result, held on result for the single cycle
// in which done is high; the receiver cannot stall it. busy is high while the
// sequencer walks the heap through a single memory read port and one shared
// 64-bit comparator: insert reads and compares one parent per step up, with
// a final write step when it reaches the root; refill reads the left child,
// reads the right child and compares for each level, with a final write step
// when it reaches an entry with no children; exhausted first fetches the
// last entry. done is high in the cycle after the last busy cycle. Refused,
// last-entry and mode 3 commands leave busy low; done is high in the cycle
// after the transfer. busy is low again in the cycle done is shown, so the
// next command can go. Reset empties the heap only.
module kway_merge_min_heap_unit #(
	parameter int SOURCES = kwm_pkg::SOURCES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  kwm_pkg::cmd_t cmd,
	output logic          done,
	output kwm_pkg::rsp_t result
);

	import kwm_pkg::*;

	localparam int AW = $clog2(SOURCES);
	localparam int CW = $clog2(SOURCES + 1);

	stat_t          stat;
	entry_t         popped;
	logic [CW-1:0]  count;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	entry_t         wr_data;
	logic           rd_en;
	logic [AW-1:0]  rd_addr;
	entry_t         rd_data;
	entry_t         root_q;

	kwm_ctrl #(
		.SOURCES (SOURCES),
		.AW      (AW),
		.CW      (CW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.root    (root_q),
		.stat    (stat),
		.popped  (popped),
		.count   (count),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	kwm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SOURCES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// copy of the root entry, kept in step with writes to position zero
	always_ff @(posedge clk) begin
		if (wr_en && wr_addr == '0) begin
			root_q <= wr_data;
		end
	end

	// result formatting
	always_comb begin
		result.popped_valid  = stat.popped_valid;
		result.popped_source = popped.source;
		result.popped_key    = popped.key;
		result.popped_size   = popped.size;
		result.refused       = stat.refused;
		result.top_valid     = (count != '0);
		result.top_source    = (count != '0) ? root_q.source : '0;
		result.entry_count   = COUNT_W'(count);
	end

	assign done = stat.done;

endmodule
